### hw/rtl/dwpid_pkg.sv
`default_nettype none
package dwpid_pkg;

    // field and datapath widths
    localparam int GoalW    = 16;
    localparam int CountW   = 32;
    localparam int TimeW    = 32;
    localparam int GainW    = 48;
    localparam int CoefW    = 16;
    localparam int PeriodW  = 10;
    localparam int TppW     = 16;
    localparam int SpeedW   = 16;
    localparam int ErrW     = 18;
    localparam int IntegW   = 48;
    localparam int MulAW    = 19;
    localparam int MulBW    = 34;
    localparam int ProdW    = 53;
    localparam int SumW     = 64;
    localparam int DivNW    = 48;
    localparam int DivDW    = 32;
    localparam int PwmW     = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 48;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_LFWD,
        REG_LREV,
        REG_RFWD,
        REG_RREV,
        REG_PERIOD,
        REG_TPP
    } cfg_reg_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MEAS_MUL,
        OP_MEAS_DIV,
        OP_MEAS_WB,
        OP_COMMIT,
        OP_ERR,
        OP_INT,
        OP_ILO,
        OP_IHI,
        OP_KD,
        OP_D_START,
        OP_D_WB,
        OP_PUSH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic wheel;
    } dp_cmd_t;

    typedef struct packed {
        logic due;
        logic div_done;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MMUL,
        ST_MDIV,
        ST_MWAIT,
        ST_COMMIT,
        ST_ERR,
        ST_INT,
        ST_ILO,
        ST_IHI,
        ST_KD,
        ST_DDIV,
        ST_DWAIT,
        ST_PUSH
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/dwpid_divider.sv
`default_nettype none
module dwpid_divider
    import dwpid_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DivNW-1:0] num,
    input  wire logic [DivDW-1:0] den,
    output logic      [DivNW-1:0] quo,
    output logic      [DivDW-1:0] rem,
    output logic                  done
);

    localparam int CntW = $clog2(DivNW);

    logic [DivNW-1:0] quo_reg, quo_next;
    logic [DivDW-1:0] rem_reg, rem_next;
    logic [DivDW-1:0] den_reg;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DivDW:0]   trial;
    logic             fits;

    // one restoring step a cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DivNW-1]};
        fits      = trial >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CntW'(DivNW - 1);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DivNW-2:0], fits};
            rem_next = fits ? DivDW'(trial - {1'b0, den_reg}) : trial[DivDW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && !done_reg))
        else $error("divider start did not begin a run");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule
`default_nettype wire

### hw/rtl/dwpid_datapath.sv
`default_nettype none
module dwpid_datapath
    import dwpid_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_cmd_t                    cmd,
    output dp_status_t                      status,
    input  wire logic                       cfg_we,
    input  wire logic [CfgIdxW-1:0]         cfg_index,
    input  wire logic [CfgDataW-1:0]        cfg_data,
    input  wire logic signed [GoalW-1:0]    goal_left,
    input  wire logic signed [GoalW-1:0]    goal_right,
    input  wire logic signed [CountW-1:0]   count_left,
    input  wire logic signed [CountW-1:0]   count_right,
    input  wire logic [TimeW-1:0]           now_ms,
    input  wire logic                       out_stall,
    output logic                            out_valid,
    output logic [PwmW-1:0]                 pwm_left,
    output logic [PwmW-1:0]                 pwm_right,
    output logic                            reverse_left,
    output logic                            reverse_right,
    output logic [SpeedW-1:0]               speed_left,
    output logic [SpeedW-1:0]               speed_right
);

    // configuration
    logic [GainW-1:0]   lfwd_reg, lrev_reg, rfwd_reg, rrev_reg;
    logic [PeriodW-1:0] period_cfg_reg;
    logic [TppW-1:0]    tpp_reg;

    // captured beat
    logic signed [GoalW-1:0] goal_l_reg, goal_r_reg;
    logic [CountW-1:0]       cnt_l_reg, cnt_r_reg;
    logic [TimeW-1:0]        now_reg, elapsed_reg;

    // controller state
    logic [CountW-1:0]       last_l_reg, last_r_reg;
    logic [TimeW-1:0]        last_time_reg;
    logic [SpeedW-1:0]       speed_reg [2];
    logic signed [IntegW-1:0] integ_reg [2];
    logic signed [ErrW-1:0]  prev_reg [2];
    logic [PwmW-1:0]         pwm_reg [2];

    // work registers
    logic signed [ErrW-1:0]   err_reg, de_reg;
    logic signed [IntegW-1:0] acc_reg;
    logic signed [ProdW-1:0]  prod_reg;
    logic signed [SumW-1:0]   sum_reg;
    logic [39:0]              itlo_reg;
    logic                     dneg_reg;

    // output stage
    logic              out_valid_reg;
    logic [PwmW-1:0]   pwm_l_out_reg, pwm_r_out_reg;
    logic              rev_l_out_reg, rev_r_out_reg;
    logic [SpeedW-1:0] spd_l_out_reg, spd_r_out_reg;

    logic signed [GoalW-1:0] goal_w;
    logic [GoalW:0]          goal_ext, abs_goal;
    logic [SpeedW-1:0]       speed_w;
    logic signed [ErrW-1:0]  err_now;
    logic [PeriodW-1:0]      period;
    logic                    rev;
    logic [GainW-1:0]        gains_w;
    logic [CoefW-1:0]        kp, ki, kd;
    logic [CountW-1:0]       delta, mag;
    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [ProdW-1:0] mul_res;
    logic signed [IntegW-1:0] integ_base, acc_now;
    logic signed [50:0]      integ_sum;
    logic [65:0]             it_hi;
    logic signed [65:0]      it_full;
    logic signed [SumW-1:0]  it_sat;
    logic [34:0]             dmag;
    logic [DivNW-1:0]        dmag_ext, dx1000;
    logic [DivNW-1:0]        div_num, div_q, qinc;
    logic [DivDW-1:0]        div_den, div_r;
    logic                    div_start, div_done;
    logic signed [SumW-1:0]  dt, total;
    logic [PwmW-1:0]         pwm_now;

    localparam logic signed [65:0] TermLim = 66'sh0_1000_0000_0000_0000;

    // wheel selection
    always_comb
    begin
        goal_w   = cmd.wheel ? goal_r_reg : goal_l_reg;
        goal_ext = {goal_w[GoalW-1], goal_w};
        abs_goal = goal_w[GoalW-1] ? (~goal_ext + 1'b1) : goal_ext;
        speed_w  = speed_reg[cmd.wheel];
        err_now  = $signed({1'b0, abs_goal}) - $signed({2'b0, speed_w});
        period   = (period_cfg_reg == '0) ? PeriodW'(1) : period_cfg_reg;
        rev      = goal_l_reg[GoalW-1] & goal_r_reg[GoalW-1];
        if (cmd.wheel)
        begin
            gains_w = rev ? rrev_reg : rfwd_reg;
        end
        else
        begin
            gains_w = rev ? lrev_reg : lfwd_reg;
        end
        kp    = gains_w[15:0];
        ki    = gains_w[31:16];
        kd    = gains_w[47:32];
        delta = cmd.wheel ? (cnt_r_reg - last_r_reg) : (cnt_l_reg - last_l_reg);
        mag   = delta[CountW-1] ? (~delta + 1'b1) : delta;
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MEAS_MUL:
            begin
                mul_a = {3'b0, tpp_reg};
                mul_b = {2'b0, mag};
            end
            OP_ERR:
            begin
                mul_a = {err_now[ErrW-1], err_now};
                mul_b = {2'b0, elapsed_reg};
            end
            OP_INT:
            begin
                mul_a = {3'b0, kp};
                mul_b = {{16{err_reg[ErrW-1]}}, err_reg};
            end
            OP_ILO:
            begin
                mul_a = {3'b0, ki};
                mul_b = {10'b0, acc_reg[23:0]};
            end
            OP_IHI:
            begin
                mul_a = {3'b0, ki};
                mul_b = {{10{acc_reg[IntegW-1]}}, acc_reg[47:24]};
            end
            OP_KD:
            begin
                mul_a = {de_reg[ErrW-1], de_reg};
                mul_b = {18'b0, kd};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    // integral accumulate with saturation
    always_comb
    begin
        integ_base = (goal_w == '0) ? '0 : integ_reg[cmd.wheel];
        integ_sum  = {{3{integ_base[IntegW-1]}}, integ_base} + prod_reg[50:0];
        if (integ_sum[50:47] == {4{integ_sum[47]}})
        begin
            acc_now = integ_sum[47:0];
        end
        else
        begin
            acc_now = integ_sum[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
    end

    // integral term reassembly and limit
    always_comb
    begin
        it_hi   = {{24{prod_reg[41]}}, prod_reg[41:0]};
        it_full = $signed(it_hi << 24) + $signed({26'b0, itlo_reg});
        if (it_full > TermLim)
        begin
            it_sat = SumW'(TermLim);
        end
        else if (it_full < -TermLim)
        begin
            it_sat = SumW'(-TermLim);
        end
        else
        begin
            it_sat = SumW'(it_full);
        end
    end

    // derivative numerator, times 1000 as 1024 - 16 - 8
    always_comb
    begin
        dmag     = prod_reg[ProdW-1] ? (~prod_reg[34:0] + 1'b1) : prod_reg[34:0];
        dmag_ext = {13'b0, dmag};
        dx1000   = (dmag_ext << 10) - (dmag_ext << 4) - (dmag_ext << 3);
    end

    // divider hookup
    always_comb
    begin
        div_start = (cmd.op == OP_MEAS_DIV) || (cmd.op == OP_D_START);
        div_num   = (cmd.op == OP_D_START) ? dx1000 : prod_reg[DivNW-1:0];
        div_den   = (cmd.op == OP_D_START) ? {22'b0, period} : elapsed_reg;
    end

    dwpid_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_q),
        .rem   (div_r),
        .done  (div_done)
    );

    // floored derivative term, final sum and pwm
    always_comb
    begin
        qinc  = div_q + DivNW'(div_r != '0);
        dt    = dneg_reg ? -$signed({16'b0, qinc}) : $signed({16'b0, div_q});
        total = sum_reg + dt;
        if ((goal_w == '0) || total[SumW-1])
        begin
            pwm_now = '0;
        end
        else if (total[SumW-1:24] != '0)
        begin
            pwm_now = '1;
        end
        else
        begin
            pwm_now = total[23:16];
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfwd_reg       <= '0;
            lrev_reg       <= '0;
            rfwd_reg       <= '0;
            rrev_reg       <= '0;
            period_cfg_reg <= PeriodW'(40);
            tpp_reg        <= TppW'(227);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LFWD:   lfwd_reg       <= cfg_data;
                REG_LREV:   lrev_reg       <= cfg_data;
                REG_RFWD:   rfwd_reg       <= cfg_data;
                REG_RREV:   rrev_reg       <= cfg_data;
                REG_PERIOD: period_cfg_reg <= cfg_data[PeriodW-1:0];
                REG_TPP:    tpp_reg        <= cfg_data[TppW-1:0];
                default:    ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_l_reg    <= '0;
            last_r_reg    <= '0;
            last_time_reg <= '0;
            speed_reg[0]  <= '0;
            speed_reg[1]  <= '0;
            integ_reg[0]  <= '0;
            integ_reg[1]  <= '0;
            prev_reg[0]   <= '0;
            prev_reg[1]   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_MEAS_WB:
                    speed_reg[cmd.wheel] <= (div_q[DivNW-1:SpeedW] != '0) ? '1
                                            : div_q[SpeedW-1:0];
                OP_COMMIT:
                begin
                    last_l_reg    <= cnt_l_reg;
                    last_r_reg    <= cnt_r_reg;
                    last_time_reg <= now_reg;
                end
                OP_ERR:
                    prev_reg[cmd.wheel] <= err_now;
                OP_INT:
                    integ_reg[cmd.wheel] <= acc_now;
                default:
                    ;
            endcase
            if (cmd.op == OP_PUSH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // work and payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_res;
        case (cmd.op)
            OP_LOAD:
            begin
                goal_l_reg  <= goal_left;
                goal_r_reg  <= goal_right;
                cnt_l_reg   <= count_left;
                cnt_r_reg   <= count_right;
                now_reg     <= now_ms;
                elapsed_reg <= now_ms - last_time_reg;
            end
            OP_ERR:
            begin
                err_reg <= err_now;
                de_reg  <= err_now - prev_reg[cmd.wheel];
            end
            OP_INT:
                acc_reg <= acc_now;
            OP_ILO:
                sum_reg <= {{11{prod_reg[ProdW-1]}}, prod_reg};
            OP_IHI:
                itlo_reg <= prod_reg[39:0];
            OP_KD:
                sum_reg <= sum_reg + it_sat;
            OP_D_START:
                dneg_reg <= prod_reg[ProdW-1];
            OP_D_WB:
                pwm_reg[cmd.wheel] <= pwm_now;
            OP_PUSH:
            begin
                pwm_l_out_reg <= pwm_reg[0];
                pwm_r_out_reg <= pwm_reg[1];
                rev_l_out_reg <= goal_l_reg[GoalW-1];
                rev_r_out_reg <= goal_r_reg[GoalW-1];
                spd_l_out_reg <= speed_reg[0];
                spd_r_out_reg <= speed_reg[1];
            end
            default:
                ;
        endcase
    end

    always_comb
    begin
        status.due      = elapsed_reg >= {22'b0, period};
        status.div_done = div_done;
        status.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign pwm_left      = pwm_l_out_reg;
    assign pwm_right     = pwm_r_out_reg;
    assign reverse_left  = rev_l_out_reg;
    assign reverse_right = rev_r_out_reg;
    assign speed_left    = spd_l_out_reg;
    assign speed_right   = spd_r_out_reg;

endmodule
`default_nettype wire

### hw/rtl/dwpid_ctrl.sv
`default_nettype none
module dwpid_ctrl
    import dwpid_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   wheel_reg, wheel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wheel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wheel_reg <= wheel_next;
        end
    end

    // sequence: optional speed sample per wheel, then pid per wheel, then push
    always_comb
    begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        cmd.op     = OP_NONE;
        cmd.wheel  = wheel_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    wheel_next = 1'b0;
                    state_next = ST_MMUL;
                end
            end
            ST_MMUL:
            begin
                if (status.due)
                begin
                    cmd.op     = OP_MEAS_MUL;
                    state_next = ST_MDIV;
                end
                else
                begin
                    state_next = ST_ERR;
                end
            end
            ST_MDIV:
            begin
                cmd.op     = OP_MEAS_DIV;
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = OP_MEAS_WB;
                    if (wheel_reg)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        wheel_next = 1'b1;
                        state_next = ST_MMUL;
                    end
                end
            end
            ST_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                wheel_next = 1'b0;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = ST_INT;
            end
            ST_INT:
            begin
                cmd.op     = OP_INT;
                state_next = ST_ILO;
            end
            ST_ILO:
            begin
                cmd.op     = OP_ILO;
                state_next = ST_IHI;
            end
            ST_IHI:
            begin
                cmd.op     = OP_IHI;
                state_next = ST_KD;
            end
            ST_KD:
            begin
                cmd.op     = OP_KD;
                state_next = ST_DDIV;
            end
            ST_DDIV:
            begin
                cmd.op     = OP_D_START;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op = OP_D_WB;
                    if (wheel_reg)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        wheel_next = 1'b1;
                        state_next = ST_ERR;
                    end
                end
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_PUSH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_push_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && !status.out_free) |=> (state_reg == ST_PUSH))
        else $error("result dropped while output stage full");

    a_sample_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MMUL && !status.due) |=> (state_reg == ST_ERR && !wheel_reg))
        else $error("speed sample not skipped cleanly");

endmodule
`default_nettype wire

### hw/rtl/dual_wheel_pid_speed_control_core.sv
// Two-wheel PID speed controller with gain scheduling.
// Input channel (in_valid / in_stall): one control tick per beat with the goal
// speeds, absolute encoder counts and the time in ms. Output channel
// (out_valid / out_stall): one result beat per tick with pwm, direction and the
// held measured speed of each wheel.
// Configuration: cfg_we writes cfg_data into register cfg_index (gain sets,
// sample period, travel per pulse); write only while the block is idle.
// Each tick runs to completion before the next is accepted: the controller
// returns to idle once the result is pushed to the output register. The run
// time is set by the shared 48-step restoring divider, used once per wheel for
// the speed when a sample is due and once per wheel for the derivative term.
// Reset: all controller state clears, gains go to zero, sample period 40 ms,
// travel per pulse 227 um.
// A stalled result is held in the output register; the block still accepts and
// works on the next tick and only waits at the end if the register is full.
`default_nettype none
module dual_wheel_pid_speed_control_core
    import dwpid_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CfgIdxW-1:0]       cfg_index,
    input  wire logic [CfgDataW-1:0]      cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [GoalW-1:0]  goal_left,
    input  wire logic signed [GoalW-1:0]  goal_right,
    input  wire logic signed [CountW-1:0] count_left,
    input  wire logic signed [CountW-1:0] count_right,
    input  wire logic [TimeW-1:0]         now_ms,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [PwmW-1:0]               pwm_left,
    output logic [PwmW-1:0]               pwm_right,
    output logic                          reverse_left,
    output logic                          reverse_right,
    output logic [SpeedW-1:0]             speed_left,
    output logic [SpeedW-1:0]             speed_right
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    dwpid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    dwpid_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .goal_left     (goal_left),
        .goal_right    (goal_right),
        .count_left    (count_left),
        .count_right   (count_right),
        .now_ms        (now_ms),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .pwm_left      (pwm_left),
        .pwm_right     (pwm_right),
        .reverse_left  (reverse_left),
        .reverse_right (reverse_right),
        .speed_left    (speed_left),
        .speed_right   (speed_right)
    );

endmodule
`default_nettype wire

### sim/tb_dual_wheel_pid_speed_control_core.sv
`timescale 1ns / 1ps
module tb_dual_wheel_pid_speed_control_core;
    import dwpid_pkg::*;

    typedef struct {
        logic [PwmW-1:0]   pwm_l;
        logic [PwmW-1:0]   pwm_r;
        logic              rev_l;
        logic              rev_r;
        logic [SpeedW-1:0] spd_l;
        logic [SpeedW-1:0] spd_r;
    } wheel_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    cfg_reg_t                 cfg_index;
    logic [CfgDataW-1:0]      cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [GoalW-1:0]  goal_left;
    logic signed [GoalW-1:0]  goal_right;
    logic signed [CountW-1:0] count_left;
    logic signed [CountW-1:0] count_right;
    logic [TimeW-1:0]         now_ms;
    logic                     out_valid;
    logic                     out_stall;
    logic [PwmW-1:0]          pwm_left;
    logic [PwmW-1:0]          pwm_right;
    logic                     reverse_left;
    logic                     reverse_right;
    logic [SpeedW-1:0]        speed_left;
    logic [SpeedW-1:0]        speed_right;

    dual_wheel_pid_speed_control_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .goal_left(goal_left), .goal_right(goal_right),
        .count_left(count_left), .count_right(count_right), .now_ms(now_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .pwm_left(pwm_left), .pwm_right(pwm_right),
        .reverse_left(reverse_left), .reverse_right(reverse_right),
        .speed_left(speed_left), .speed_right(speed_right)
    );

    // controller model state
    logic [GainW-1:0]   gain_set [4];
    logic [PeriodW-1:0] cfg_period;
    logic [TppW-1:0]    cfg_tpp;
    logic [31:0]        prev_cnt_l, prev_cnt_r, prev_time;
    logic [15:0]        held_spd_l, held_spd_r;
    longint             integ_l, integ_r, last_err_l, last_err_r;

    wheel_result_t pending_results [$];
    int            errors;
    int            send_idle, recv_idle;
    int            hold_len;
    int            hold_cnt;

    // stimulus trajectory
    logic [31:0] cur_time;
    logic [31:0] cur_cl, cur_cr;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [15:0] wheel_speed(input logic [31:0] cnt, input logic [31:0] last,
                                                input logic [31:0] elapsed);
        logic [31:0] d;
        logic [63:0] mag, v;
        d = cnt - last;
        mag = d[31] ? {32'd0, 32'd0 - d} : {32'd0, d};
        v = mag * {48'd0, cfg_tpp} / {32'd0, elapsed};
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [7:0] pid_duty(input int goal, input logic [GainW-1:0] gains,
                                            input logic [15:0] spd, input logic [31:0] elapsed,
                                            input longint per, inout longint integ,
                                            inout longint last_err);
        longint kp, ki, kd, err, acc, de, pt, it, dt, num, sum;
        kp = longint'(gains[15:0]);
        ki = longint'(gains[31:16]);
        kd = longint'(gains[47:32]);
        err = longint'(goal < 0 ? -goal : goal) - longint'(spd);
        if (goal == 0)
            integ = 0;
        acc = integ + err * longint'({32'd0, elapsed});
        if (acc > 64'sd140737488355327)
            acc = 64'sd140737488355327;
        if (acc < -64'sd140737488355328)
            acc = -64'sd140737488355328;
        integ = acc;
        de = err - last_err;
        last_err = err;
        pt = kp * err;
        it = ki * acc;
        if (it > 64'sd1152921504606846976)
            it = 64'sd1152921504606846976;
        if (it < -64'sd1152921504606846976)
            it = -64'sd1152921504606846976;
        // floor division for the derivative term
        num = kd * de * 1000;
        dt = num / per;
        if ((num % per) != 0 && num < 0)
            dt = dt - 1;
        sum = pt + it + dt;
        if (goal == 0 || sum < 0)
            return 8'd0;
        sum = sum >>> 16;
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    // expected result of one accepted tick
    function automatic wheel_result_t predict_tick(input logic signed [15:0] gl,
                                                   input logic signed [15:0] gr,
                                                   input logic [31:0] cl, input logic [31:0] cr,
                                                   input logic [31:0] now);
        wheel_result_t r;
        logic [31:0] elapsed;
        longint per;
        logic rev;
        elapsed = now - prev_time;
        per = (cfg_period == 0) ? 1 : longint'(cfg_period);
        rev = gl < 0 && gr < 0;
        if (longint'({32'd0, elapsed}) >= per)
        begin
            held_spd_l = wheel_speed(cl, prev_cnt_l, elapsed);
            held_spd_r = wheel_speed(cr, prev_cnt_r, elapsed);
            prev_cnt_l = cl;
            prev_cnt_r = cr;
            prev_time = now;
        end
        r.pwm_l = pid_duty(int'(gl), rev ? gain_set[1] : gain_set[0], held_spd_l, elapsed, per,
                           integ_l, last_err_l);
        r.pwm_r = pid_duty(int'(gr), rev ? gain_set[3] : gain_set[2], held_spd_r, elapsed, per,
                           integ_r, last_err_r);
        r.rev_l = gl < 0;
        r.rev_r = gr < 0;
        r.spd_l = held_spd_l;
        r.spd_r = held_spd_r;
        return r;
    endfunction

    // receiver: random stall plus long hold-off
    always @(negedge clk)
    begin
        if (hold_len != 0)
        begin
            hold_cnt = hold_len;
            hold_len = 0;
        end
        if (hold_cnt > 0)
            hold_cnt--;
        out_stall <= (hold_cnt > 0) || ($urandom_range(0, 99) < recv_idle);
    end

    // result checker
    always @(posedge clk)
    begin
        wheel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("unexpected result beat", 0, 0);
            else
            begin
                want = pending_results.pop_front();
                if (pwm_left !== want.pwm_l) report("pwm_left", pwm_left, want.pwm_l);
                if (pwm_right !== want.pwm_r) report("pwm_right", pwm_right, want.pwm_r);
                if (reverse_left !== want.rev_l) report("reverse_left", reverse_left, want.rev_l);
                if (reverse_right !== want.rev_r)
                    report("reverse_right", reverse_right, want.rev_r);
                if (speed_left !== want.spd_l) report("speed_left", speed_left, want.spd_l);
                if (speed_right !== want.spd_r) report("speed_right", speed_right, want.spd_r);
            end
        end
    end

    task automatic send_tick(input logic signed [15:0] gl, input logic signed [15:0] gr,
                             input logic [31:0] cl, input logic [31:0] cr,
                             input logic [31:0] now);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        goal_left   <= gl;
        goal_right  <= gr;
        count_left  <= cl;
        count_right <= cr;
        now_ms      <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_tick(gl, gr, cl, cr, now));
    endtask

    // wait for every result, then let the datapath settle
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [47:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LFWD:   gain_set[0] = value;
            REG_LREV:   gain_set[1] = value;
            REG_RFWD:   gain_set[2] = value;
            REG_RREV:   gain_set[3] = value;
            REG_PERIOD: cfg_period = value[PeriodW-1:0];
            REG_TPP:    cfg_tpp = value[TppW-1:0];
            default:    ;
        endcase
    endtask

    function automatic logic [47:0] random_gains;
        logic [15:0] p, i, d;
        if ($urandom_range(0, 9) == 0)
            return 48'({$urandom(), $urandom()});
        p = 16'($urandom_range(0, 3000));
        i = 16'($urandom_range(0, 300));
        d = 16'($urandom_range(0, 200));
        return {d, i, p};
    endfunction

    function automatic logic signed [15:0] random_goal;
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'sd0;
        if (k == 1)
            return 16'($urandom());
        return 16'($urandom_range(0, 1400) - 700);
    endfunction

    // mostly a plausible trajectory, some noise and jumps
    task automatic random_ticks(input int n);
        int per;
        logic signed [15:0] gl, gr;
        for (int k = 0; k < n; k++)
        begin
            per = (cfg_period == 0) ? 1 : int'(cfg_period);
            if ($urandom_range(0, 19) == 0)
                cur_time = $urandom();
            else
                cur_time = cur_time + $urandom_range(0, 2 * per);
            if ($urandom_range(0, 19) == 0)
                cur_cl = $urandom();
            else
                cur_cl = cur_cl + $urandom_range(0, 400) - 200;
            if ($urandom_range(0, 19) == 0)
                cur_cr = $urandom();
            else
                cur_cr = cur_cr + $urandom_range(0, 400) - 200;
            gl = random_goal();
            gr = random_goal();
            if ($urandom_range(0, 4) == 0)
            begin
                gl = -16'($urandom_range(1, 700));
                gr = -16'($urandom_range(1, 700));
            end
            send_tick(gl, gr, cur_cl, cur_cr, cur_time);
        end
    endtask

    task automatic random_setting(input logic [9:0] per, input logic [15:0] tpp);
        cfg_write(REG_LFWD, random_gains());
        cfg_write(REG_LREV, random_gains());
        cfg_write(REG_RFWD, random_gains());
        cfg_write(REG_RREV, random_gains());
        cfg_write(REG_PERIOD, {38'd0, per});
        cfg_write(REG_TPP, {32'd0, tpp});
    endtask

    // extremes and the named corner cases
    task automatic test_directed;
        send_idle = 0;
        recv_idle = 0;
        // reset gains: all duties zero, speed from reset period
        send_tick(16'sd200, 16'sd200, 32'd100, 32'd100, 32'd40);
        drain();
        cfg_write(REG_LFWD, {16'd50, 16'd20, 16'd2000});
        cfg_write(REG_LREV, {16'd80, 16'd10, 16'd1500});
        cfg_write(REG_RFWD, {16'd40, 16'd30, 16'd2500});
        cfg_write(REG_RREV, {16'd60, 16'd15, 16'd1200});
        // no sample due, then sample due
        send_tick(16'sd300, 16'sd300, 32'd150, 32'd160, 32'd50);
        send_tick(16'sd300, -16'sd300, 32'd180, 32'd120, 32'd100);
        // both negative picks the reverse sets
        send_tick(-16'sd250, -16'sd400, 32'd160, 32'd90, 32'd150);
        // zero goals clear integrators
        send_tick(16'sd0, 16'sd0, 32'd160, 32'd90, 32'd200);
        // goal extremes
        send_tick(16'sh7FFF, -16'sh8000, 32'h7FFFFFFF, 32'h80000000, 32'd300);
        send_tick(-16'sh8000, 16'sh7FFF, 32'h80000000, 32'h7FFFFFFF, 32'd400);
        // count wrap and time wrap
        send_tick(16'sd100, 16'sd100, 32'hFFFFFFF0, 32'h00000010, 32'hFFFFFFF0);
        send_tick(16'sd100, 16'sd100, 32'h00000020, 32'hFFFFFFE0, 32'h00000030);
        drain();
        // huge integral term with full gains and long gaps
        cfg_write(REG_LFWD, 48'hFFFF_FFFF_FFFF);
        cfg_write(REG_RFWD, 48'hFFFF_FFFF_FFFF);
        cfg_write(REG_TPP, 48'd65535);
        cfg_write(REG_PERIOD, 48'd1000);
        send_tick(16'sd32767, 16'sd32767, 32'd0, 32'd0, 32'h80000000);
        send_tick(16'sd32767, 16'sd32767, 32'd0, 32'd0, 32'hFFFFFFFF);
        send_tick(16'sd32767, 16'sd32767, 32'd0, 32'd0, 32'h7FFFFFFF);
        send_tick(-16'sd1, 16'sd1, 32'h12345678, 32'hEDCBA987, 32'h7FFFFFFF);
        drain();
        // zero sample period and zero travel per pulse
        cfg_write(REG_PERIOD, 48'd0);
        cfg_write(REG_TPP, 48'd0);
        send_tick(16'sd500, 16'sd500, 32'd1000, 32'd2000, 32'h80000001);
        send_tick(16'sd500, 16'sd500, 32'd1000, 32'd2000, 32'h80000001);
        drain();
        cfg_write(REG_TPP, 48'd1);
        send_tick(16'sd500, -16'sd500, 32'd3000, 32'd5000, 32'h80000002);
        drain();
        cur_time = 32'h80000002;
        cur_cl = 32'd3000;
        cur_cr = 32'd5000;
    endtask

    task automatic test_random;
        random_setting(10'd40, 16'd227);
        send_idle = 23;
        recv_idle = 56;
        random_ticks(250);
        drain();
        random_setting(10'd1, 16'd1);
        send_idle = 56;
        recv_idle = 23;
        random_ticks(150);
        drain();
        random_setting(10'd1000, 16'd65535);
        random_ticks(100);
        drain();
        random_setting(10'($urandom_range(1, 200)), 16'($urandom_range(1, 2000)));
        send_idle = 0;
        recv_idle = 0;
        random_ticks(220);
        drain();
    endtask

    // receiver holds off while ticks keep coming, block fills and stalls input
    task automatic test_backpressure;
        send_idle = 0;
        recv_idle = 0;
        hold_len = 3000;
        random_ticks(12);
        drain();
    endtask

    initial
    begin
        errors = 0;
        send_idle = 0;
        recv_idle = 0;
        hold_len = 0;
        hold_cnt = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LFWD;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        goal_left = '0;
        goal_right = '0;
        count_left = '0;
        count_right = '0;
        now_ms = '0;
        for (int k = 0; k < 4; k++)
            gain_set[k] = '0;
        cfg_period = 10'd40;
        cfg_tpp = 16'd227;
        prev_cnt_l = '0;
        prev_cnt_r = '0;
        prev_time = '0;
        held_spd_l = '0;
        held_spd_r = '0;
        integ_l = 0;
        integ_r = 0;
        last_err_l = 0;
        last_err_r = 0;
        cur_time = '0;
        cur_cl = '0;
        cur_cr = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dwpid_pkg.sv
hw/rtl/dwpid_divider.sv
hw/rtl/dwpid_datapath.sv
hw/rtl/dwpid_ctrl.sv
hw/rtl/dual_wheel_pid_speed_control_core.sv
sim/tb_dual_wheel_pid_speed_control_core.sv
